// File: hdl/srdf_pkg.sv
// Shared types and constants for the signed radix digit formatter.
// Used by every module under hdl; depends on nothing else.
package srdf_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned NUM_SYMBOLS = 16;
    localparam int unsigned MAX_RADIX   = 16;
    // A magnitude of at most 2^31 never needs more than 32 digits.
    localparam int unsigned MAX_DIGITS  = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int unsigned STEP_W      = $clog2(NUM_SYMBOLS);
    localparam int unsigned BIT_CNT_W   = $clog2(VALUE_W);
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned ADDR_W      = 5;

    localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] SYM_NONE  = 8'h00;

    localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
    localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

    typedef enum logic [1:0] {
        REG_RADIX        = 2'd0,
        REG_SYMBOLS_LOW  = 2'd1,
        REG_SYMBOLS_HIGH = 2'd2
    } reg_index_t;

    typedef logic [NUM_SYMBOLS-1:0][CHAR_W-1:0] sym_table_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_EMIT,
        ST_INVALID
    } state_t;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_status_t;

endpackage

// File: hdl/srdf_base_check.sv
// Base validation: radix range, forbidden symbols and repeated symbols.
// Repeats are found by rotating a copy of the symbol table one byte a cycle.
// Depends on srdf_pkg.
module srdf_base_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [srdf_pkg::RADIX_W-1:0]   radix,
    input  srdf_pkg::sym_table_t           symbols,
    output srdf_pkg::chk_status_t          status
);
    import srdf_pkg::*;

    sym_table_t               rot_reg;
    sym_table_t               rot_next;
    sym_table_t               rot_src;
    logic [NUM_SYMBOLS-1:0]   rmask_reg;
    logic [NUM_SYMBOLS-1:0]   rmask_next;
    logic [NUM_SYMBOLS-1:0]   mask_src;
    logic [NUM_SYMBOLS-1:0]   act;
    logic [STEP_W-1:0]        step_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic                     ok_reg;
    logic                     range_ok;
    logic                     forbid_any;
    logic                     dup_any;
    logic                     last_step;

    always_comb
    begin
        for (int j = 0; j < NUM_SYMBOLS; j++)
        begin
            act[j] = RADIX_W'(j) < radix;
        end
    end

    assign range_ok  = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
    assign last_step = step_reg == STEP_W'(NUM_SYMBOLS - 1);

    always_comb
    begin
        forbid_any = 1'b0;
        dup_any    = 1'b0;
        for (int j = 0; j < NUM_SYMBOLS; j++)
        begin
            if (act[j] && (symbols[j] == SYM_NONE || symbols[j] == SYM_MINUS ||
                           symbols[j] == SYM_PLUS))
            begin
                forbid_any = 1'b1;
            end
            // Lane j holds the symbol step_reg places further along the table.
            if (act[j] && rmask_reg[j] && symbols[j] == rot_reg[j])
            begin
                dup_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        rot_src  = start ? symbols : rot_reg;
        mask_src = start ? act : rmask_reg;
        for (int j = 0; j < NUM_SYMBOLS; j++)
        begin
            rot_next[j]   = rot_src[(j + 1) % NUM_SYMBOLS];
            rmask_next[j] = mask_src[(j + 1) % NUM_SYMBOLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start || busy_reg)
        begin
            rot_reg   <= rot_next;
            rmask_reg <= rmask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(1);
                ok_reg   <= range_ok && !forbid_any;
            end
            else if (busy_reg)
            begin
                ok_reg   <= ok_reg && !dup_any;
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

// File: hdl/srdf_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, remainder is one digit.
// A continue request divides the previous quotient again. Depends on srdf_pkg.
module srdf_serial_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           cont,
    input  logic [srdf_pkg::VALUE_W-1:0]   dividend,
    input  logic [srdf_pkg::RADIX_W-1:0]   radix,
    output logic [srdf_pkg::DIGIT_W-1:0]   digit,
    output srdf_pkg::div_status_t          status
);
    import srdf_pkg::*;

    logic [VALUE_W-1:0]   q_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RADIX_W-1:0]   trial;
    logic [RADIX_W-1:0]   diff;
    logic                 ge;

    // The remainder stays below the radix, so the trial value fits the radix width.
    assign trial    = RADIX_W'({rem_reg, q_reg[VALUE_W-1]});
    assign ge       = trial >= radix;
    assign diff     = trial - radix;
    assign rem_next = ge ? DIGIT_W'(diff) : DIGIT_W'(trial);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (cont)
        begin
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[VALUE_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start || cont)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BIT_CNT_W'(VALUE_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - BIT_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign digit            = rem_reg;
    assign status.done      = done_reg;
    assign status.quot_zero = q_reg == '0;

endmodule

// File: hdl/srdf_digit_stack.sv
// Digit stack as a shift register: digits enter at the top and leave from the top,
// so the last digit found (the most significant) leaves first. Depends on srdf_pkg.
module srdf_digit_stack (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           push,
    input  logic                           pop,
    input  logic [srdf_pkg::DIGIT_W-1:0]   push_digit,
    output logic [srdf_pkg::DIGIT_W-1:0]   top_digit,
    output logic [srdf_pkg::CNT_W-1:0]     count
);
    import srdf_pkg::*;

    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] stack_reg;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] stack_next;
    logic [CNT_W-1:0]                   count_reg;

    always_comb
    begin
        stack_next = stack_reg;
        if (push)
        begin
            stack_next = {push_digit, stack_reg[MAX_DIGITS-1:1]};
        end
        else if (pop)
        begin
            stack_next = {stack_reg[MAX_DIGITS-2:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clear)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign top_digit = stack_reg[MAX_DIGITS-1];
    assign count     = count_reg;

endmodule

// File: hdl/signed_radix_digit_formatter_unit.sv
// Top level of the signed radix digit formatter: register port, sequencer, output stage.
// Depends on srdf_pkg, srdf_base_check, srdf_serial_div and srdf_digit_stack.
//
// Each accepted value is printed in the programmed radix, most significant digit first,
// one byte per transfer, with a leading minus sign for negative values. One value is
// handled at a time: the base check runs first, then the one-bit-per-cycle divider finds
// each digit in turn, after which the sign and digits leave at one per cycle when the
// output is not stalled. An invalid base gives one transfer with last and base_invalid
// set. Registers sit at byte addresses 0, 8 and 16; they are to be written only while
// the block is idle, which the block itself does not enforce.
module signed_radix_digit_formatter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srdf_pkg::ADDR_W-1:0]         paddr,
    input  logic [srdf_pkg::CFG_W-1:0]          pwdata,
    output logic [srdf_pkg::CFG_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [srdf_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [srdf_pkg::CHAR_W-1:0]         character,
    output logic                                last,
    output logic                                base_invalid
);
    import srdf_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [CFG_W-1:0]   symbols_low_reg;
    logic [CFG_W-1:0]   symbols_high_reg;
    sym_table_t         symbols;
    reg_index_t         reg_idx;
    logic               cfg_write;

    state_t             state_reg;
    state_t             state_next;
    logic               neg_reg;
    logic [VALUE_W-1:0] mag_reg;
    logic [VALUE_W-1:0] raw;
    logic               accept;
    logic               slot_free;

    chk_status_t        chk;
    div_status_t        div;
    logic [DIGIT_W-1:0] div_digit;
    logic [DIGIT_W-1:0] top_digit;
    logic [CNT_W-1:0]   digit_count;

    logic               chk_start;
    logic               div_start;
    logic               div_cont;
    logic               stk_clear;
    logic               stk_push;
    logic               stk_pop;
    logic               emit_fire;
    logic [CHAR_W-1:0]  emit_char;
    logic               emit_last;
    logic               emit_inv;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  character_reg;
    logic               last_reg;
    logic               base_invalid_reg;

    // Register port
    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign symbols   = {symbols_high_reg, symbols_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_RADIX:        radix_reg        <= pwdata[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= pwdata;
                REG_SYMBOLS_HIGH: symbols_high_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RADIX:        prdata = CFG_W'(radix_reg);
            REG_SYMBOLS_LOW:  prdata = symbols_low_reg;
            REG_SYMBOLS_HIGH: prdata = symbols_high_reg;
            default:          prdata = '0;
        endcase
    end

    // Input side
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = state_reg != ST_IDLE;
    assign slot_free = !out_valid_reg || !out_stall;
    assign raw       = value;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= raw[VALUE_W-1];
            // Negation on the full width leaves the most negative value as 2^31, exact.
            mag_reg <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
        end
    end

    srdf_base_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (chk_start),
        .radix   (radix_reg),
        .symbols (symbols),
        .status  (chk)
    );

    srdf_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .cont     (div_cont),
        .dividend (mag_reg),
        .radix    (radix_reg),
        .digit    (div_digit),
        .status   (div)
    );

    srdf_digit_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (stk_clear),
        .push       (stk_push),
        .pop        (stk_pop),
        .push_digit (div_digit),
        .top_digit  (top_digit),
        .count      (digit_count)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk.done)
                begin
                    state_next = chk.ok ? ST_DIV : ST_INVALID;
                end
            end
            ST_DIV:
            begin
                if (div.done && div.quot_zero)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && digit_count == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INVALID:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        chk_start = 1'b0;
        stk_clear = 1'b0;
        div_start = 1'b0;
        div_cont  = 1'b0;
        stk_push  = 1'b0;
        stk_pop   = 1'b0;
        emit_fire = 1'b0;
        emit_char = SYM_NONE;
        emit_last = 1'b0;
        emit_inv  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                chk_start = accept;
                stk_clear = accept;
            end
            ST_CHECK:
            begin
                div_start = chk.done && chk.ok;
            end
            ST_DIV:
            begin
                stk_push = div.done;
                div_cont = div.done && !div.quot_zero;
            end
            ST_SIGN:
            begin
                emit_fire = slot_free;
                emit_char = SYM_MINUS;
            end
            ST_EMIT:
            begin
                emit_fire = slot_free;
                stk_pop   = slot_free;
                emit_char = symbols[top_digit];
                emit_last = digit_count == CNT_W'(1);
            end
            ST_INVALID:
            begin
                emit_fire = slot_free;
                emit_last = 1'b1;
                emit_inv  = 1'b1;
            end
            default:
            begin
                emit_fire = 1'b0;
            end
        endcase
    end

    // Output register: loads whenever the previous transfer has gone or is going now.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= emit_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            character_reg    <= emit_char;
            last_reg         <= emit_last;
            base_invalid_reg <= emit_inv;
        end
    end

    assign out_valid    = out_valid_reg;
    assign character    = character_reg;
    assign last         = last_reg;
    assign base_invalid = base_invalid_reg;

`ifndef SYNTH
    a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && base_invalid) |-> last)
        else $error("invalid-base transfer without last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("new value taken while one is in progress");

    a_last_not_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && !base_invalid) |-> (character != SYM_MINUS))
        else $error("minus sign sent as final character");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for signed_radix_digit_formatter_unit: directed table, then random bases and values.
// Depends on srdf_pkg and the RTL under hdl; expected text comes from the table or a local formatter model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srdf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned BASE_PHASES    = 16;
    localparam int unsigned VALID_ITEMS    = 22;
    localparam int unsigned FLAWED_ITEMS   = 6;

    localparam logic [CFG_W-1:0] DEC_LO   = SYMBOLS_LOW_RESET;
    localparam logic [CFG_W-1:0] DEC_HI   = SYMBOLS_HIGH_RESET;
    // Inactive bytes hold repeats and forbidden symbols on purpose.
    localparam logic [CFG_W-1:0] BIN_LO   = 64'h3030_3030_3030_3130;
    localparam logic [CFG_W-1:0] BIN_HI   = 64'h2B2D_002B_2D00_2B2D;
    localparam logic [CFG_W-1:0] HEX_LO   = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0] HEX_HI   = 64'h4645_4443_4241_3938;
    localparam logic [CFG_W-1:0] TRI_LO   = 64'h2B2D_002B_2D63_6261;
    localparam logic [CFG_W-1:0] TOP_LO   = 64'hF7F6_F5F4_F3F2_F1F0;
    localparam logic [CFG_W-1:0] TOP_HI   = 64'hFFFE_FDFC_FBFA_F9F8;
    localparam logic [CFG_W-1:0] PLUS_HI  = 64'h0000_0000_0000_2B38;
    localparam logic [CFG_W-1:0] MINUS_LO = 64'h3736_3534_3332_312D;
    localparam logic [CFG_W-1:0] REP_HI   = 64'h3045_4443_4241_3938;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              inv;
    } text_byte_t;

    typedef struct {
        value_t num;
        bit     typed;
        string  golden;
        bit     golden_inv;
    } value_job_t;

    typedef struct {
        logic [RADIX_W-1:0] radix;
        logic [CFG_W-1:0]   sym_lo;
        logic [CFG_W-1:0]   sym_hi;
        value_t             num;
        bit                 typed;
        string              golden;
        bit                 golden_inv;
    } directed_row_t;

    typedef enum {
        FLAW_NONE,
        FLAW_RADIX_LOW,
        FLAW_RADIX_HIGH,
        FLAW_FORBIDDEN,
        FLAW_REPEAT
    } base_flaw_t;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_RUNS
    } stall_style_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [CFG_W-1:0]   pwdata    = '0;
    logic [CFG_W-1:0]   prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    value_t             value     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic               base_invalid;

    logic [RADIX_W-1:0] cfg_radix        = RADIX_RESET;
    logic [CFG_W-1:0]   cfg_symbols_low  = SYMBOLS_LOW_RESET;
    logic [CFG_W-1:0]   cfg_symbols_high = SYMBOLS_HIGH_RESET;

    value_job_t  waiting_values_q[$];
    text_byte_t  expected_text_q[$];

    int unsigned mismatch_count   = 0;
    int unsigned values_accepted  = 0;
    int unsigned bytes_checked    = 0;
    int unsigned flagged_results  = 0;
    int unsigned bases_applied    = 0;
    int unsigned quiet_cycles     = 0;
    int unsigned burst_left       = 1;
    int unsigned gap_left         = 0;
    int unsigned stall_span       = 0;
    int unsigned stall_run        = 0;
    stall_style_t stall_style     = STALL_NONE;
    logic        stall_level      = 1'b0;

    directed_row_t directed_rows[23] = '{
        '{5'd10, DEC_LO,   DEC_HI, 32'sd0,            1'b1, "0",           1'b0},
        '{5'd10, DEC_LO,   DEC_HI, 32'sd2147483647,   1'b1, "2147483647",  1'b0},
        '{5'd10, DEC_LO,   DEC_HI, 32'sh8000_0000,    1'b1, "-2147483648", 1'b0},
        '{5'd10, DEC_LO,   DEC_HI, -32'sd1,           1'b1, "-1",          1'b0},
        '{5'd10, DEC_LO,   DEC_HI, -32'sd90817,       1'b0, "",            1'b0},
        '{5'd2,  BIN_LO,   BIN_HI, 32'sh8000_0000,    1'b1,
          "-10000000000000000000000000000000",                             1'b0},
        '{5'd2,  BIN_LO,   BIN_HI, 32'sd2147483647,   1'b0, "",            1'b0},
        '{5'd2,  BIN_LO,   BIN_HI, 32'sd0,            1'b1, "0",           1'b0},
        '{5'd16, HEX_LO,   HEX_HI, 32'sd2147483647,   1'b1, "7FFFFFFF",    1'b0},
        '{5'd16, HEX_LO,   HEX_HI, 32'sh8000_0000,    1'b1, "-80000000",   1'b0},
        '{5'd16, HEX_LO,   HEX_HI, 32'shDEAD_BEEF,    1'b0, "",            1'b0},
        '{5'd3,  TRI_LO,   HEX_HI, 32'sd100,          1'b0, "",            1'b0},
        '{5'd16, TOP_LO,   TOP_HI, -32'sd123456789,   1'b0, "",            1'b0},
        '{5'd16, TOP_LO,   TOP_HI, 32'sd2147483647,   1'b0, "",            1'b0},
        '{5'd0,  DEC_LO,   DEC_HI, 32'sd5,            1'b1, "",            1'b1},
        '{5'd1,  DEC_LO,   DEC_HI, 32'sd5,            1'b1, "",            1'b1},
        '{5'd17, DEC_LO,   DEC_HI, 32'sd5,            1'b1, "",            1'b1},
        '{5'd31, DEC_LO,   DEC_HI, -32'sd5,           1'b1, "",            1'b1},
        '{5'd10, DEC_LO,  PLUS_HI, 32'sd12,           1'b1, "",            1'b1},
        '{5'd10, MINUS_LO, DEC_HI, 32'sd12,           1'b1, "",            1'b1},
        '{5'd11, DEC_LO,   DEC_HI, 32'sd12,           1'b1, "",            1'b1},
        '{5'd16, HEX_LO,   REP_HI, 32'sd12,           1'b1, "",            1'b1},
        '{5'd10, DEC_LO,   DEC_HI, 32'sd1,            1'b1, "1",           1'b0}
    };

    signed_radix_digit_formatter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .character    (character),
        .last         (last),
        .base_invalid (base_invalid)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic bit base_is_valid(input logic [RADIX_W-1:0] r, input sym_table_t tbl);
        if (r < 2 || r > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < r; i++)
        begin
            if (tbl[i] == SYM_NONE || tbl[i] == SYM_PLUS || tbl[i] == SYM_MINUS)
                return 1'b0;
            for (int j = i + 1; j < r; j++)
                if (tbl[j] == tbl[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Appends the text of one value under the current base to the expected bytes.
    function automatic void push_formatted_text(input value_t num);
        sym_table_t         tbl;
        logic [VALUE_W:0]   mag;
        logic [DIGIT_W-1:0] digit_q[$];
        tbl = {cfg_symbols_high, cfg_symbols_low};
        if (!base_is_valid(cfg_radix, tbl))
        begin
            expected_text_q.push_back('{SYM_NONE, 1'b1, 1'b1});
            return;
        end
        // The extra bit keeps the magnitude of the most negative value exact.
        mag = {num[VALUE_W-1], num};
        if (num[VALUE_W-1])
        begin
            mag = ~mag + 1'b1;
            expected_text_q.push_back('{SYM_MINUS, 1'b0, 1'b0});
        end
        do
        begin
            digit_q.push_front(DIGIT_W'(mag % cfg_radix));
            mag = mag / cfg_radix;
        end
        while (mag != 0);
        foreach (digit_q[i])
            expected_text_q.push_back('{tbl[digit_q[i]], i == digit_q.size() - 1, 1'b0});
    endfunction

    function automatic value_t pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2:
                return VALUE_W'($urandom_range(0, 400)) - VALUE_W'(200);
            3, 4:
            begin
                v = $urandom >> $urandom_range(0, 31);
                return ($urandom_range(0, 1) == 1) ? -v : v;
            end
            default:
                return $urandom;
        endcase
    endfunction

    // Draws a base of distinct legal symbols, then spoils it when a flaw is asked for.
    function automatic void pick_base(input base_flaw_t flaw, input int unsigned fixed_radix,
                                      output logic [RADIX_W-1:0] r,
                                      output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi);
        sym_table_t        tbl;
        bit                used[256];
        logic [CHAR_W-1:0] s;
        int unsigned       i;
        int unsigned       j;
        used = '{default: 1'b0};
        used[SYM_NONE]  = 1'b1;
        used[SYM_PLUS]  = 1'b1;
        used[SYM_MINUS] = 1'b1;
        r = (fixed_radix != 0) ? RADIX_W'(fixed_radix) : RADIX_W'($urandom_range(2, MAX_RADIX));
        for (i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (i < r)
            begin
                do
                    s = CHAR_W'($urandom);
                while (used[s]);
                used[s] = 1'b1;
                tbl[i] = s;
            end
            else
                tbl[i] = CHAR_W'($urandom);
        end
        case (flaw)
            FLAW_RADIX_LOW:
                r = RADIX_W'($urandom_range(0, 1));
            FLAW_RADIX_HIGH:
                r = RADIX_W'($urandom_range(MAX_RADIX + 1, (1 << RADIX_W) - 1));
            FLAW_FORBIDDEN:
            begin
                case ($urandom_range(0, 2))
                    0:       s = SYM_NONE;
                    1:       s = SYM_PLUS;
                    default: s = SYM_MINUS;
                endcase
                tbl[$urandom_range(0, r - 1)] = s;
            end
            FLAW_REPEAT:
            begin
                i = $urandom_range(0, r - 2);
                j = $urandom_range(i + 1, r - 1);
                tbl[j] = tbl[i];
            end
            default:
                ;
        endcase
        {hi, lo} = tbl;
    endfunction

    // Writes one register, reads it back, and updates the local copy of the settings.
    task automatic write_register(input reg_index_t idx, input logic [CFG_W-1:0] data);
        logic [CFG_W-1:0] readback;
        logic [CFG_W-1:0] mask;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        mask = (idx == REG_RADIX) ? CFG_W'((1 << RADIX_W) - 1) : '1;
        if ((readback & mask) !== (data & mask))
            report_mismatch($sformatf("register %s reads %016h after writing %016h",
                                      idx.name(), readback, data));
        case (idx)
            REG_RADIX:        cfg_radix        = data[RADIX_W-1:0];
            REG_SYMBOLS_LOW:  cfg_symbols_low  = data;
            REG_SYMBOLS_HIGH: cfg_symbols_high = data;
            default:          ;
        endcase
    endtask

    task automatic wait_until_drained();
        while (waiting_values_q.size() != 0 || expected_text_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic apply_base(input logic [RADIX_W-1:0] r,
                              input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] radix_word;
        if (r == cfg_radix && lo == cfg_symbols_low && hi == cfg_symbols_high)
            return;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        // Upper bits of the radix word are noise that the register must drop.
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = r;
        if (r != cfg_radix)
            write_register(REG_RADIX, radix_word);
        if (lo != cfg_symbols_low)
            write_register(REG_SYMBOLS_LOW, lo);
        if (hi != cfg_symbols_high)
            write_register(REG_SYMBOLS_HIGH, hi);
        bases_applied++;
    endtask

    // Value sender: bursts of transfers separated by random gaps.
    always @(posedge clk)
    begin
        logic       nxt_valid;
        value_job_t job;
        nxt_valid = in_valid;
        if (!rst_n)
            nxt_valid = 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                job = waiting_values_q.pop_front();
                values_accepted++;
                if (!job.typed)
                    push_formatted_text(job.num);
                else if (job.golden_inv)
                    expected_text_q.push_back('{SYM_NONE, 1'b1, 1'b1});
                else
                    for (int i = 0; i < job.golden.len(); i++)
                        expected_text_q.push_back('{job.golden[i], i == job.golden.len() - 1,
                                                    1'b0});
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (waiting_values_q.size() != 0)
                begin
                    nxt_valid = 1'b1;
                    value <= waiting_values_q[0].num;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
        in_valid <= nxt_valid;
    end

    // Text receiver: the stall style is redrawn at the end of each randomly drawn span.
    always @(posedge clk)
    begin
        logic nxt_stall;
        if (stall_span == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 400);
        end
        else
            stall_span--;
        case (stall_style)
            STALL_NONE:  nxt_stall = 1'b0;
            STALL_COIN:  nxt_stall = ($urandom_range(0, 1) == 0);
            STALL_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_level = ~stall_level;
                    stall_run = $urandom_range(1, 24);
                end
                else
                    stall_run--;
                nxt_stall = stall_level;
            end
        endcase
        out_stall <= rst_n ? nxt_stall : 1'b0;
    end

    always @(posedge clk)
    begin
        text_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (base_invalid)
                flagged_results++;
            if (expected_text_q.size() == 0)
                report_mismatch($sformatf("byte %02h last %0b invalid %0b with nothing expected",
                                          character, last, base_invalid));
            else
            begin
                want = expected_text_q.pop_front();
                if (character !== want.ch || last !== want.last || base_invalid !== want.inv)
                    report_mismatch($sformatf(
                        "got byte %02h last %0b invalid %0b, expected %02h %0b %0b",
                        character, last, base_invalid, want.ch, want.last, want.inv));
            end
        end
    end

    // Any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles without a transfer", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [RADIX_W-1:0] r;
        logic [CFG_W-1:0]   lo;
        logic [CFG_W-1:0]   hi;
        base_flaw_t         flaw;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            apply_base(directed_rows[i].radix, directed_rows[i].sym_lo, directed_rows[i].sym_hi);
            waiting_values_q.push_back('{directed_rows[i].num, directed_rows[i].typed,
                                         directed_rows[i].golden, directed_rows[i].golden_inv});
        end

        // Binary and full hexadecimal width first, then random radixes; every fourth base is flawed.
        for (int phase = 0; phase < BASE_PHASES; phase++)
        begin
            flaw = (phase % 4 == 3) ? base_flaw_t'(1 + (phase / 4) % 4) : FLAW_NONE;
            pick_base(flaw, (phase == 0) ? 2 : (phase == 1) ? 16 : 0, r, lo, hi);
            apply_base(r, lo, hi);
            repeat ((flaw == FLAW_NONE) ? VALID_ITEMS : FLAWED_ITEMS)
                waiting_values_q.push_back('{pick_value(), 1'b0, "", 1'b0});
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_text_q.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived", expected_text_q.size()));

        $display("Formatted %0d values under %0d base settings; %0d bytes compared.",
                 values_accepted, bases_applied, bytes_checked);
        $display("%0d results flagged an invalid base; %0d mismatches seen.",
                 flagged_results, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
